// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file tsi_checker.sv.
// Depends on a clk_i / rst_ni pair in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define TSI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tsi: assertion failed");

// Clocked implication, disabled while reset is held.
`define TSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tsi: implication failed");

`endif

// ===== src/tsi_pkg.sv =====
// Types, constants and helpers of the timestamped sample interpolator.
// No dependencies; used by the interface, top, lane, checker and testbench files.
package tsi_pkg;

  localparam int ENTITIES  = 64;
  localparam int DEPTH     = 12;
  localparam int TICK_RATE = 30;

  localparam int SLOTS  = (ENTITIES < 64) ? ENTITIES : 64;
  localparam int ENT_W  = 6;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int HA_W   = $clog2(SLOTS * DEPTH);
  localparam int MA_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CFG_W  = 10;
  localparam int CFG_IDX_W = 1;
  localparam int NF     = 7;     // pos x/y/z, vel x/y/z, heading
  localparam int F_VEL  = 3;     // first velocity field
  localparam int MAG_W  = 33;
  localparam int PROD_W = 65;
  localparam int QUO_W  = 42;    // quotient bound: |vel| * 1023 / 1
  localparam int SAT_W  = 44;
  localparam int DCNT_W = $clog2(QUO_W);

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERP_DELAY = 1'b0,
    CFG_MAX_EXTRAP   = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_META,
    ST_PUSH_CHK,
    ST_WRITE,
    ST_WALK0,
    ST_WALK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ENT_W-1:0]   entity_id;
    logic [31:0]        tick;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] heading;
  } req_t;

  typedef struct packed {
    logic               found;
    logic               extrapolated;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic signed [31:0] out_heading;
  } rsp_t;

  typedef struct packed {
    logic [31:0]          tick;
    logic [NF-1:0][31:0]  f;
  } sample_t;

  typedef struct packed {
    logic [SLOT_W-1:0] start;
    logic [CNT_W-1:0]  fill;
  } meta_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
  } lane_ctl_t;

  localparam int SAMPLE_W = $bits(sample_t);
  localparam int META_W   = $bits(meta_t);

  // (start + k) mod DEPTH, for start below DEPTH and k at most DEPTH
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] start,
                                                 input logic [CNT_W-1:0] k);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(start) + (CNT_W+1)'(k);
    if (sum >= (CNT_W+1)'(DEPTH)) sum = sum - (CNT_W+1)'(DEPTH);
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [HA_W-1:0] hist_addr(input logic [ENT_W-1:0] e,
                                                input logic [SLOT_W-1:0] s);
    return HA_W'(e) * HA_W'(DEPTH) + HA_W'(s);
  endfunction

endpackage

// ===== src/tsi_if.sv =====
// Valid/ready channel interfaces for request and response transactions.
// Depends on tsi_pkg.
interface tsi_in_if;
  logic          valid;
  logic          ready;
  tsi_pkg::req_t req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface tsi_out_if;
  logic          valid;
  logic          ready;
  tsi_pkg::rsp_t rsp;
  modport source (output valid, output rsp, input ready);
  modport sink   (input valid, input rsp, output ready);
endinterface

// ===== src/timestamped_sample_interpolator.sv =====
// Timestamped sample interpolator. Keeps a ring of up to DEPTH samples per
// entity in one history RAM (entity * DEPTH + slot) plus a per-entity ring
// descriptor RAM; per-entity valid bits make reset and clear instant. One
// transaction at a time: clear and unused kinds are done on acceptance; a
// push reads its descriptor, then the newest tick (skipped for an empty ring),
// then writes (skipped for a stale tick); a query walks its ring one sample
// per cycle, ends later while the previous result still waits in the output
// register, and when it must blend or extrapolate, seven lanes run a split
// low/high multiply and a bit-serial divide; the divide loop sets the length
// of a blending query. A finished result sits in an output register, so the
// next transaction is taken while it waits. Depends on tsi_pkg, tsi_if,
// tsi_ram, tsi_lane.
module timestamped_sample_interpolator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tsi_in_if.sink                         in_ch,
  tsi_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  logic [tsi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tsi_pkg::CFG_W-1:0]      cfg_data_i
);
  tsi_pkg::state_e state_q, state_d;

  logic [tsi_pkg::CFG_W-1:0] delay_q, max_ex_q;
  logic [tsi_pkg::SLOTS-1:0] valid_q;

  tsi_pkg::req_t    req_q;
  logic [31:0]      target_q;
  tsi_pkg::sample_t prev_q, oldest_q;
  logic [tsi_pkg::SLOT_W-1:0] start_q;
  logic [tsi_pkg::CNT_W-1:0]  fill_q, k_q;
  logic [tsi_pkg::DCNT_W-1:0] dcnt_q;
  tsi_pkg::sample_t res_q;
  logic             found_q, extrap_q, use_lane_q;
  logic             out_vld_q;
  tsi_pkg::rsp_t    out_q;

  // memories
  logic                           h_we;
  logic [tsi_pkg::HA_W-1:0]       h_waddr, h_raddr;
  logic [tsi_pkg::SAMPLE_W-1:0]   h_wdata, h_rdata;
  logic                           m_we;
  logic [tsi_pkg::MA_W-1:0]       m_waddr, m_raddr;
  logic [tsi_pkg::META_W-1:0]     m_wdata, m_rdata;
  tsi_pkg::sample_t rd, push_s;
  tsi_pkg::meta_t   meta_rd, meta_new;

  logic accept, entity_ok, in_win, is_last, ext_ok, push_newer;
  logic [31:0] ahead;
  logic [tsi_pkg::SLOT_W-1:0] wr_slot;

  tsi_pkg::lane_ctl_t ctl;
  logic signed [31:0] lane_base [tsi_pkg::NF];
  logic signed [32:0] lane_d    [tsi_pkg::NF];
  logic signed [31:0] lane_res  [tsi_pkg::NF];
  logic [31:0]        lane_off, lane_span;

  assign accept    = in_ch.valid && in_ch.ready;
  assign entity_ok = (7'(in_ch.req.entity_id) < 7'(tsi_pkg::SLOTS));
  assign rd        = tsi_pkg::sample_t'(h_rdata);

  // descriptor as seen after its read; an invalid entry reads as empty ring
  always_comb begin
    meta_rd = tsi_pkg::meta_t'(m_rdata);
    if (!valid_q[req_q.entity_id]) meta_rd = '0;
  end

  assign push_newer = req_q.tick > rd.tick;
  assign in_win     = (prev_q.tick <= target_q) && (target_q <= rd.tick);
  assign is_last    = (k_q == fill_q - tsi_pkg::CNT_W'(1));
  assign ahead      = target_q - rd.tick;
  assign ext_ok     = (target_q > rd.tick) && (ahead <= 32'(max_ex_q));

  // push write slot and the updated descriptor
  always_comb begin
    meta_new = '{start: start_q, fill: fill_q};
    if (fill_q < tsi_pkg::CNT_W'(tsi_pkg::DEPTH)) begin
      wr_slot       = tsi_pkg::slot_add(start_q, fill_q);
      meta_new.fill = fill_q + tsi_pkg::CNT_W'(1);
    end else begin
      // full ring: overwrite oldest, advance start
      wr_slot        = start_q;
      meta_new.start = tsi_pkg::slot_add(start_q, tsi_pkg::CNT_W'(1));
    end
  end

  always_comb begin
    push_s.tick = req_q.tick;
    push_s.f[0] = req_q.pos_x;
    push_s.f[1] = req_q.pos_y;
    push_s.f[2] = req_q.pos_z;
    push_s.f[3] = req_q.vel_x;
    push_s.f[4] = req_q.vel_y;
    push_s.f[5] = req_q.vel_z;
    push_s.f[6] = req_q.heading;
  end

  // lane operands: blend prev/rd inside the window, else extrapolate from rd
  always_comb begin
    lane_off  = in_win ? target_q - prev_q.tick : ahead;
    lane_span = in_win ? rd.tick - prev_q.tick : 32'(tsi_pkg::TICK_RATE);
    for (int j = 0; j < tsi_pkg::NF; j++) begin
      lane_base[j] = in_win ? prev_q.f[j] : rd.f[j];
      lane_d[j]    = in_win ? {rd.f[j][31], rd.f[j]} - {prev_q.f[j][31], prev_q.f[j]}
                            : '0;
    end
    if (!in_win) begin
      for (int j = 0; j < tsi_pkg::F_VEL; j++) begin
        lane_d[j] = {rd.f[tsi_pkg::F_VEL+j][31], rd.f[tsi_pkg::F_VEL+j]};
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsi_pkg::ST_IDLE: begin
        if (accept && entity_ok) begin
          if (in_ch.req.kind == tsi_pkg::KIND_PUSH ||
              in_ch.req.kind == tsi_pkg::KIND_QUERY) state_d = tsi_pkg::ST_META;
        end else if (accept && in_ch.req.kind == tsi_pkg::KIND_QUERY) begin
          state_d = tsi_pkg::ST_FINISH;
        end
      end
      tsi_pkg::ST_META: begin
        if (req_q.kind == tsi_pkg::KIND_PUSH)
          state_d = (meta_rd.fill == '0) ? tsi_pkg::ST_WRITE : tsi_pkg::ST_PUSH_CHK;
        else
          state_d = (meta_rd.fill == '0) ? tsi_pkg::ST_FINISH : tsi_pkg::ST_WALK0;
      end
      tsi_pkg::ST_PUSH_CHK: state_d = push_newer ? tsi_pkg::ST_WRITE : tsi_pkg::ST_IDLE;
      tsi_pkg::ST_WRITE:    state_d = tsi_pkg::ST_IDLE;
      tsi_pkg::ST_WALK0:
        state_d = (fill_q == tsi_pkg::CNT_W'(1)) ? tsi_pkg::ST_FINISH : tsi_pkg::ST_WALK;
      tsi_pkg::ST_WALK: begin
        if (in_win || (is_last && ext_ok)) state_d = tsi_pkg::ST_MUL_LO;
        else if (is_last)                  state_d = tsi_pkg::ST_FINISH;
      end
      tsi_pkg::ST_MUL_LO: state_d = tsi_pkg::ST_MUL_HI;
      tsi_pkg::ST_MUL_HI: state_d = tsi_pkg::ST_DIV;
      tsi_pkg::ST_DIV:
        if (dcnt_q == tsi_pkg::DCNT_W'(tsi_pkg::QUO_W - 1)) state_d = tsi_pkg::ST_FINISH;
      tsi_pkg::ST_FINISH:
        if (!out_vld_q || out_ch.ready) state_d = tsi_pkg::ST_IDLE;
      default: state_d = tsi_pkg::ST_IDLE;
    endcase
  end

  // outputs: memory ports, lane control, handshake
  always_comb begin
    in_ch.ready = 1'b0;
    h_we        = 1'b0;
    h_waddr     = tsi_pkg::hist_addr(req_q.entity_id, wr_slot);
    h_wdata     = push_s;
    h_raddr     = tsi_pkg::hist_addr(req_q.entity_id, start_q);
    m_we        = 1'b0;
    m_waddr     = tsi_pkg::MA_W'(req_q.entity_id);
    m_wdata     = meta_new;
    m_raddr     = tsi_pkg::MA_W'(in_ch.req.entity_id);
    ctl         = '0;
    unique case (state_q)
      tsi_pkg::ST_IDLE: in_ch.ready = 1'b1;
      tsi_pkg::ST_META: begin
        if (req_q.kind == tsi_pkg::KIND_PUSH)
          h_raddr = tsi_pkg::hist_addr(req_q.entity_id,
                      tsi_pkg::slot_add(meta_rd.start, meta_rd.fill - tsi_pkg::CNT_W'(1)));
        else
          h_raddr = tsi_pkg::hist_addr(req_q.entity_id, meta_rd.start);
      end
      tsi_pkg::ST_WRITE: begin
        h_we = 1'b1;
        m_we = 1'b1;
      end
      tsi_pkg::ST_WALK0:
        h_raddr = tsi_pkg::hist_addr(req_q.entity_id,
                    tsi_pkg::slot_add(start_q, tsi_pkg::CNT_W'(1)));
      tsi_pkg::ST_WALK: begin
        h_raddr  = tsi_pkg::hist_addr(req_q.entity_id,
                     tsi_pkg::slot_add(start_q, k_q + tsi_pkg::CNT_W'(1)));
        ctl.load = in_win || (is_last && ext_ok);
      end
      tsi_pkg::ST_MUL_LO: ctl.mul_lo   = 1'b1;
      tsi_pkg::ST_MUL_HI: ctl.mul_hi   = 1'b1;
      tsi_pkg::ST_DIV:    ctl.div_step = 1'b1;
      tsi_pkg::ST_PUSH_CHK, tsi_pkg::ST_FINISH: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tsi_pkg::ST_IDLE;
      delay_q   <= tsi_pkg::CFG_W'(2);
      max_ex_q  <= tsi_pkg::CFG_W'(3);
      valid_q   <= '0;
      out_vld_q <= 1'b0;
      dcnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tsi_pkg::CFG_INTERP_DELAY: delay_q  <= cfg_data_i;
          tsi_pkg::CFG_MAX_EXTRAP:   max_ex_q <= cfg_data_i;
          default: ;
        endcase
      end
      // clear drops every ring at once
      if (accept && in_ch.req.kind == tsi_pkg::KIND_CLEAR) valid_q <= '0;
      if (state_q == tsi_pkg::ST_WRITE) valid_q[req_q.entity_id] <= 1'b1;
      dcnt_q <= (state_q == tsi_pkg::ST_DIV) ? dcnt_q + tsi_pkg::DCNT_W'(1) : '0;
      if (state_q == tsi_pkg::ST_FINISH && state_d == tsi_pkg::ST_IDLE)
        out_vld_q <= 1'b1;
      else if (out_ch.ready)
        out_vld_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= in_ch.req;
      target_q   <= (in_ch.req.tick > 32'(delay_q)) ? in_ch.req.tick - 32'(delay_q) : '0;
      res_q      <= '0;
      found_q    <= 1'b0;
      extrap_q   <= 1'b0;
      use_lane_q <= 1'b0;
    end
    unique case (state_q)
      tsi_pkg::ST_META: begin
        start_q <= meta_rd.start;
        fill_q  <= meta_rd.fill;
        found_q <= (meta_rd.fill != '0);
      end
      tsi_pkg::ST_WALK0: begin
        oldest_q <= rd;
        prev_q   <= rd;
        res_q    <= rd;   // lone sample goes out as is
        k_q      <= tsi_pkg::CNT_W'(1);
      end
      tsi_pkg::ST_WALK: begin
        prev_q <= rd;
        k_q    <= k_q + tsi_pkg::CNT_W'(1);
        if (in_win || (is_last && ext_ok)) begin
          use_lane_q <= 1'b1;
          extrap_q   <= !in_win;
        end else if (is_last) begin
          res_q <= oldest_q;
        end
      end
      default: ;
    endcase
    if (state_q == tsi_pkg::ST_FINISH && state_d == tsi_pkg::ST_IDLE) begin
      out_q.found        <= found_q;
      out_q.extrapolated <= extrap_q;
      out_q.out_pos_x    <= use_lane_q ? lane_res[0] : res_q.f[0];
      out_q.out_pos_y    <= use_lane_q ? lane_res[1] : res_q.f[1];
      out_q.out_pos_z    <= use_lane_q ? lane_res[2] : res_q.f[2];
      out_q.out_vel_x    <= use_lane_q ? lane_res[3] : res_q.f[3];
      out_q.out_vel_y    <= use_lane_q ? lane_res[4] : res_q.f[4];
      out_q.out_vel_z    <= use_lane_q ? lane_res[5] : res_q.f[5];
      out_q.out_heading  <= use_lane_q ? lane_res[6] : res_q.f[6];
    end
  end

  assign out_ch.valid = out_vld_q;
  assign out_ch.rsp   = out_q;

  tsi_ram #(.W(tsi_pkg::SAMPLE_W), .D(tsi_pkg::SLOTS * tsi_pkg::DEPTH)) u_hist (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rdata)
  );

  tsi_ram #(.W(tsi_pkg::META_W), .D(tsi_pkg::SLOTS)) u_meta (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(m_wdata),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  for (genvar g = 0; g < tsi_pkg::NF; g++) begin : g_lane
    tsi_lane u_lane (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .base_i(lane_base[g]),
      .d_i   (lane_d[g]),
      .off_i (lane_off),
      .span_i(lane_span),
      .res_o (lane_res[g])
    );
  end
endmodule

// ===== src/tsi_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module tsi_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== src/tsi_lane.sv =====
// One blend lane: base +/- |d| * off / span, truncated, saturated to 32 bits.
// Split low/high multiply, then one quotient bit per cycle. Depends on tsi_pkg.
module tsi_lane (
  input  logic                clk_i,
  input  tsi_pkg::lane_ctl_t  ctl_i,
  input  logic signed [31:0]  base_i,
  input  logic signed [32:0]  d_i,
  input  logic [31:0]         off_i,
  input  logic [31:0]         span_i,
  output logic signed [31:0]  res_o
);
  logic [tsi_pkg::MAG_W-1:0]  mag_q;
  logic                       neg_q;
  logic [31:0]                off_q, span_q;
  logic signed [31:0]         base_q;
  logic [48:0]                plo_q;
  logic [31:0]                rem_q;
  logic [tsi_pkg::PROD_W-1:0] quo_q;
  logic [tsi_pkg::PROD_W-1:0] prod;
  logic [32:0]                trial;
  logic                       ge;
  logic signed [tsi_pkg::SAT_W-1:0] sum;

  assign prod  = tsi_pkg::PROD_W'(plo_q)
               + ((tsi_pkg::PROD_W'(mag_q) * tsi_pkg::PROD_W'(off_q[31:16])) << 16);
  assign trial = {rem_q, quo_q[tsi_pkg::PROD_W-1]};
  assign ge    = trial >= {1'b0, span_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      neg_q  <= d_i[32];
      mag_q  <= d_i[32] ? tsi_pkg::MAG_W'(-d_i) : tsi_pkg::MAG_W'(d_i);
      off_q  <= off_i;
      span_q <= span_i;
      base_q <= base_i;
    end
    if (ctl_i.mul_lo) plo_q <= 49'(mag_q) * 49'(off_q[15:0]);
    if (ctl_i.mul_hi) begin
      // top bits already below span since the quotient fits QUO_W
      rem_q <= 32'(prod[tsi_pkg::PROD_W-1:tsi_pkg::QUO_W]);
      quo_q <= prod << (tsi_pkg::PROD_W - tsi_pkg::QUO_W);
    end
    if (ctl_i.div_step) begin
      rem_q <= ge ? 32'(trial - {1'b0, span_q}) : trial[31:0];
      quo_q <= {quo_q[tsi_pkg::PROD_W-2:0], ge};
    end
  end

  always_comb begin
    sum = neg_q ? tsi_pkg::SAT_W'(base_q) - tsi_pkg::SAT_W'(quo_q[tsi_pkg::QUO_W-1:0])
                : tsi_pkg::SAT_W'(base_q) + tsi_pkg::SAT_W'(quo_q[tsi_pkg::QUO_W-1:0]);
    if (sum > tsi_pkg::SAT_W'(32'sh7fffffff))       res_o = 32'sh7fffffff;
    else if (sum < -(tsi_pkg::SAT_W'(33'sh80000000))) res_o = 32'sh80000000;
    else                                            res_o = sum[31:0];
  end
endmodule

// ===== src/tsi_checker.sv =====
// Port-level checks of the timestamped sample interpolator, bound to the top.
// Depends on tsi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tsi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic        extrapolated,
  input logic [31:0] out_pos_x,
  input logic [31:0] out_heading
);
  `TSI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `TSI_ASSERT_IMP(a_extrap_found, out_valid, !extrapolated || found)
  `TSI_ASSERT_IMP(a_empty_zero, out_valid && !found, out_pos_x == '0 && out_heading == '0)
  `TSI_ASSERT(a_busy_after_push, in_valid && in_ready && in_kind == tsi_pkg::KIND_PUSH |=> !in_ready)
endmodule

bind timestamped_sample_interpolator tsi_checker u_tsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_kind     (in_ch.req.kind),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .found       (out_ch.rsp.found),
  .extrapolated(out_ch.rsp.extrapolated),
  .out_pos_x   (out_ch.rsp.out_pos_x),
  .out_heading (out_ch.rsp.out_heading)
);

// ===== tb/sv/timestamped_sample_interpolator_test.sv =====
// Testbench of the timestamped sample interpolator: directed table, then random
// push/query/clear and unused-kind traffic checked against an in-bench history predictor.
// Depends on tsi_pkg, tsi_if and the block's RTL.
`timescale 1ns / 1ps

module timestamped_sample_interpolator_test;

  localparam int EXP_N = 4096;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [tsi_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [tsi_pkg::CFG_W-1:0] cfg_data_i = '0;

  tsi_in_if in_ch ();
  tsi_out_if out_ch ();

  timestamped_sample_interpolator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------- predictor state ----------------
  logic [9:0] delay_q, extrap_lim_q;
  logic [31:0] pred_tick [64][tsi_pkg::DEPTH];
  logic signed [31:0] pred_val [64][tsi_pkg::DEPTH][tsi_pkg::NF]; // pos xyz, vel xyz, heading
  int unsigned pred_start [64];
  int unsigned pred_fill [64];
  logic [31:0] last_tick [64]; // stimulus helper: tick of the last push sent

  // expected results, in order
  tsi_pkg::rsp_t exp_fifo [EXP_N];
  int exp_wr = 0;
  int exp_rd = 0;
  int errors = 0;
  int stall_cnt = 0;
  bit timed_out = 0;

  function automatic void exp_put(tsi_pkg::rsp_t r);
    exp_fifo[exp_wr % EXP_N] = r;
    exp_wr++;
  endfunction

  function automatic tsi_pkg::rsp_t exp_take();
    tsi_pkg::rsp_t r;
    r = exp_fifo[exp_rd % EXP_N];
    exp_rd++;
    return r;
  endfunction

  function automatic logic signed [31:0] blend(logic signed [31:0] a,
      logic signed [31:0] b, logic [31:0] off, logic [31:0] span);
    longint d;
    logic [63:0] mag, q;
    if (span == 0) return a;
    d = longint'(b) - longint'(a);
    mag = (d < 0) ? -d : d;
    q = mag * {32'd0, off} / {32'd0, span};
    return (d < 0) ? 32'(longint'(a) - longint'(q)) : 32'(longint'(a) + longint'(q));
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] p, longint step);
    longint s;
    s = longint'(p) + step;
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return 32'(s);
  endfunction

  function automatic void fill_from(ref tsi_pkg::rsp_t r, input int e, input int s);
    r.out_pos_x = pred_val[e][s][0]; r.out_pos_y = pred_val[e][s][1];
    r.out_pos_z = pred_val[e][s][2]; r.out_vel_x = pred_val[e][s][3];
    r.out_vel_y = pred_val[e][s][4]; r.out_vel_z = pred_val[e][s][5];
    r.out_heading = pred_val[e][s][6];
  endfunction

  // Applies one accepted transaction to the history model; queues a result for queries.
  function automatic void history_apply(tsi_pkg::req_t t);
    int e, n, s, sa, sb, sn;
    tsi_pkg::rsp_t r;
    logic [31:0] target, ahead;
    logic signed [31:0] fv [tsi_pkg::NF];
    e = t.entity_id;
    n = pred_fill[e];
    r = '0;
    case (tsi_pkg::kind_e'(t.kind))
      tsi_pkg::KIND_CLEAR: foreach (pred_fill[i]) begin
        pred_fill[i] = 0; pred_start[i] = 0;
      end
      tsi_pkg::KIND_PUSH: begin
        // stale tick: dropped
        if (n > 0 && t.tick <= pred_tick[e][(pred_start[e] + n - 1) % tsi_pkg::DEPTH]) return;
        if (n < tsi_pkg::DEPTH) begin
          s = (pred_start[e] + n) % tsi_pkg::DEPTH; pred_fill[e]++;
        end else begin
          s = pred_start[e]; pred_start[e] = (pred_start[e] + 1) % tsi_pkg::DEPTH;
        end
        fv = '{t.pos_x, t.pos_y, t.pos_z, t.vel_x, t.vel_y, t.vel_z, t.heading};
        pred_tick[e][s] = t.tick;
        for (int j = 0; j < tsi_pkg::NF; j++) pred_val[e][s][j] = fv[j];
      end
      tsi_pkg::KIND_QUERY: begin
        if (n > 0) begin
          r.found = 1'b1;
          if (n == 1) begin
            fill_from(r, e, pred_start[e]);
            exp_put(r);
            return;
          end
          target = (t.tick > delay_q) ? t.tick - delay_q : 0;
          for (int k = 0; k + 1 < n; k++) begin
            sa = (pred_start[e] + k) % tsi_pkg::DEPTH;
            sb = (pred_start[e] + k + 1) % tsi_pkg::DEPTH;
            if (target < pred_tick[e][sa] || target > pred_tick[e][sb]) continue;
            for (int j = 0; j < tsi_pkg::NF; j++)
              fv[j] = blend(pred_val[e][sa][j], pred_val[e][sb][j],
                            target - pred_tick[e][sa], pred_tick[e][sb] - pred_tick[e][sa]);
            {r.out_pos_x, r.out_pos_y, r.out_pos_z, r.out_vel_x, r.out_vel_y,
             r.out_vel_z, r.out_heading} = {fv[0], fv[1], fv[2], fv[3], fv[4], fv[5], fv[6]};
            exp_put(r);
            return;
          end
          sn = (pred_start[e] + n - 1) % tsi_pkg::DEPTH;
          ahead = target - pred_tick[e][sn];
          if (target > pred_tick[e][sn] && ahead <= extrap_lim_q) begin
            fill_from(r, e, sn);
            r.out_pos_x = sat_add(pred_val[e][sn][0],
                            longint'(pred_val[e][sn][3]) * longint'(ahead) / tsi_pkg::TICK_RATE);
            r.out_pos_y = sat_add(pred_val[e][sn][1],
                            longint'(pred_val[e][sn][4]) * longint'(ahead) / tsi_pkg::TICK_RATE);
            r.out_pos_z = sat_add(pred_val[e][sn][2],
                            longint'(pred_val[e][sn][5]) * longint'(ahead) / tsi_pkg::TICK_RATE);
            r.extrapolated = 1'b1;
          end else begin
            fill_from(r, e, pred_start[e]);
          end
        end
        exp_put(r);
      end
      default: ;
    endcase
  endfunction

  // ---------------- result check ----------------
  int stall_mode = 0;
  int out_cnt = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_cnt <= out_cnt + 1;
      // receiver stall pattern: modes are picked at random among none, periodic and random
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= (out_cnt % 5) < 3;
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
      if (out_cnt % 300 == 0) stall_mode <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    tsi_pkg::rsp_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_r = exp_take();
        if (out_ch.rsp.found !== exp_r.found) begin
          $error("found exp %0d got %0d", exp_r.found, out_ch.rsp.found); errors++; end
        if (out_ch.rsp.extrapolated !== exp_r.extrapolated) begin
          $error("extrapolated exp %0d got %0d", exp_r.extrapolated, out_ch.rsp.extrapolated);
          errors++; end
        if (out_ch.rsp.out_pos_x !== exp_r.out_pos_x) begin
          $error("out_pos_x exp %0d got %0d", exp_r.out_pos_x, out_ch.rsp.out_pos_x); errors++; end
        if (out_ch.rsp.out_pos_y !== exp_r.out_pos_y) begin
          $error("out_pos_y exp %0d got %0d", exp_r.out_pos_y, out_ch.rsp.out_pos_y); errors++; end
        if (out_ch.rsp.out_pos_z !== exp_r.out_pos_z) begin
          $error("out_pos_z exp %0d got %0d", exp_r.out_pos_z, out_ch.rsp.out_pos_z); errors++; end
        if (out_ch.rsp.out_vel_x !== exp_r.out_vel_x) begin
          $error("out_vel_x exp %0d got %0d", exp_r.out_vel_x, out_ch.rsp.out_vel_x); errors++; end
        if (out_ch.rsp.out_vel_y !== exp_r.out_vel_y) begin
          $error("out_vel_y exp %0d got %0d", exp_r.out_vel_y, out_ch.rsp.out_vel_y); errors++; end
        if (out_ch.rsp.out_vel_z !== exp_r.out_vel_z) begin
          $error("out_vel_z exp %0d got %0d", exp_r.out_vel_z, out_ch.rsp.out_vel_z); errors++; end
        if (out_ch.rsp.out_heading !== exp_r.out_heading) begin
          $error("out_heading exp %0d got %0d", exp_r.out_heading, out_ch.rsp.out_heading);
          errors++; end
      end
    end
  end

  // Watchdog: ends the run with FAIL when neither channel handshakes for longer
  // than its limit, which is many times a blending query plus receiver stalls.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > 5000 && !timed_out) begin
      timed_out = 1;
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  typedef struct {
    tsi_pkg::req_t t;
    bit            check_now; // expected result typed in below
    tsi_pkg::rsp_t typed;
  } stim_row_t;

  stim_row_t dir_rows [32];
  int n_rows = 0;
  int burst_left = 0;

  function automatic void add_row(stim_row_t r);
    dir_rows[n_rows] = r;
    n_rows++;
  endfunction

  // Drives one transaction, honoring the sender's burst/gap pattern.
  task automatic send_txn(tsi_pkg::req_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_ch.req <= t;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    history_apply(t);
    burst_left--;
  endtask

  task automatic idle_wait();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (80) @(posedge clk_i); // a push gives no result but may still be running
  endtask

  task automatic write_reg(tsi_pkg::cfg_idx_e idx, logic [9:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tsi_pkg::CFG_INTERP_DELAY) delay_q = v; else extrap_lim_q = v;
    @(posedge clk_i);
  endtask

  function automatic tsi_pkg::req_t mk(tsi_pkg::kind_e k, logic [5:0] e, logic [31:0] tk,
                                       logic signed [31:0] v);
    tsi_pkg::req_t t;
    t = '{kind: k, entity_id: e, tick: tk, pos_x: v, pos_y: -v, pos_z: v ^ 32'h5a5a,
          vel_x: v, vel_y: -v, vel_z: 32'sd65536, heading: v};
    return t;
  endfunction

  function automatic tsi_pkg::req_t rand_req(int mode);
    tsi_pkg::req_t t;
    int e;
    t.kind = tsi_pkg::KIND_PUSH;
    t.entity_id = 6'($urandom_range(0, 7)); // few entities so histories fill and wrap
    if ($urandom_range(0, 9) == 0) t.entity_id = 6'($urandom);
    e = t.entity_id;
    {t.pos_x, t.pos_y, t.pos_z, t.vel_x, t.vel_y, t.vel_z, t.heading} =
      {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 1)) begin // keep x values modest half of the time
      t.pos_x = $signed(t.pos_x) >>> 8; t.vel_x = $signed(t.vel_x) >>> 4;
    end
    case (mode)
      0: begin // well-formed push: newer tick
        t.tick = last_tick[e] + $urandom_range(1, 5);
        if ($urandom_range(0, 199) == 0) t.tick = $urandom; // big jump / stale
        last_tick[e] = t.tick;
      end
      1: begin // query around the history
        t.kind = tsi_pkg::KIND_QUERY;
        t.tick = last_tick[e] + delay_q - $urandom_range(0, 40) + $urandom_range(0, 8);
        if ($urandom_range(0, 19) == 0) t.tick = $urandom;
      end
      2: begin t.kind = tsi_pkg::KIND_CLEAR; t.tick = $urandom; end
      default: begin t.kind = tsi_pkg::KIND_NONE; t.tick = $urandom; end
    endcase
    return t;
  endfunction

  initial begin
    int m, pick;
    stim_row_t row;
    in_ch.valid = 1'b0;
    in_ch.req = '0;
    delay_q = 10'd2;
    extrap_lim_q = 10'd3;
    foreach (pred_fill[i]) begin
      pred_fill[i] = 0; pred_start[i] = 0; last_tick[i] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: empty query, lone sample, bracket, stale push,
    // extrapolation with saturation, fallback, clear, unused kind.
    row.check_now = 1; row.typed = '0;
    row.t = mk(tsi_pkg::KIND_QUERY, 6'd63, 32'hffffffff, 0); add_row(row); // empty
    row.check_now = 0;
    row.t = mk(tsi_pkg::KIND_PUSH, 6'd1, 32'd0, 32'sh7fffffff); add_row(row);
    row.t = mk(tsi_pkg::KIND_QUERY, 6'd1, 32'd0, 0); add_row(row);            // lone
    row.t = mk(tsi_pkg::KIND_PUSH, 6'd1, 32'd0, 0); add_row(row);             // stale
    row.t = mk(tsi_pkg::KIND_PUSH, 6'd1, 32'd10, 32'sh80000000); add_row(row);
    row.t = mk(tsi_pkg::KIND_QUERY, 6'd1, 32'd7, 0); add_row(row);            // blend
    row.t = mk(tsi_pkg::KIND_QUERY, 6'd1, 32'd12, 0); add_row(row);           // at newest
    row.t = mk(tsi_pkg::KIND_QUERY, 6'd1, 32'd15, 0); add_row(row);           // extrapolate
    row.t = mk(tsi_pkg::KIND_QUERY, 6'd1, 32'd16, 0); add_row(row);           // past limit
    row.t = mk(tsi_pkg::KIND_QUERY, 6'd1, 32'd1, 0); add_row(row);            // floor to 0
    row.t = mk(tsi_pkg::KIND_PUSH, 6'd1, 32'hffffffff, 32'sh7fffffff); add_row(row);
    row.t = mk(tsi_pkg::KIND_PUSH, 6'd0, 32'd5, 32'sh7fff0000); add_row(row);
    row.t = mk(tsi_pkg::KIND_PUSH, 6'd0, 32'd6, 32'sh7fff0000); add_row(row);
    row.t = mk(tsi_pkg::KIND_QUERY, 6'd0, 32'd11, 0); add_row(row);           // saturate
    row.t = mk(tsi_pkg::KIND_NONE, 6'd0, 32'd0, 0); add_row(row);
    row.t = mk(tsi_pkg::KIND_CLEAR, 6'd0, 32'd0, 0); add_row(row);
    row.check_now = 1;
    row.t = mk(tsi_pkg::KIND_QUERY, 6'd1, 32'd7, 0); add_row(row);            // cleared
    for (int i = 0; i < n_rows; i++) begin
      send_txn(dir_rows[i].t);
      if (dir_rows[i].check_now) exp_fifo[(exp_wr - 1) % EXP_N] = dir_rows[i].typed;
    end
    idle_wait();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(tsi_pkg::CFG_INTERP_DELAY, 10'd0);
          write_reg(tsi_pkg::CFG_MAX_EXTRAP, 10'd0);
        end
        1: begin
          write_reg(tsi_pkg::CFG_INTERP_DELAY, 10'd1023);
          write_reg(tsi_pkg::CFG_MAX_EXTRAP, 10'd1023);
        end
        default: begin
          write_reg(tsi_pkg::CFG_INTERP_DELAY, 10'($urandom_range(0, 12)));
          write_reg(tsi_pkg::CFG_MAX_EXTRAP, 10'($urandom_range(0, 12)));
        end
      endcase
      for (int i = 0; i < 250; i++) begin
        pick = $urandom_range(0, 99);
        m = (pick < 50) ? 0 : (pick < 97) ? 1 : (pick < 99) ? 2 : 3;
        send_txn(rand_req(m));
        if (i == 125 && ph == 3) idle_wait(); // drain fully mid-phase
      end
      idle_wait();
      foreach (last_tick[i]) if (pred_fill[i] == 0 && $urandom_range(0, 1)) last_tick[i] = 0;
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/tsi_pkg.sv
src/tsi_if.sv
src/tsi_ram.sv
src/tsi_lane.sv
src/timestamped_sample_interpolator.sv
src/tsi_checker.sv
tb/sv/timestamped_sample_interpolator_test.sv
